>>> hdl/heat_palette_index_mapper_core_macros.svh
// Assertion macros for the heat palette index mapper.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef HEAT_PALETTE_INDEX_MAPPER_CORE_MACROS_SVH
`define HEAT_PALETTE_INDEX_MAPPER_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define HPIM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle, reset included
`define HPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/hpim_pkg.sv
// Shared types, widths and codes for the heat palette index mapper.
// No dependencies.
`default_nettype none

package hpim_pkg;

  localparam int unsigned XW    = 33;   // sign-extended sample / limit width
  localparam int unsigned DEN_W = 33;   // divisor width (high - low)
  localparam int unsigned NUM_W = 50;   // dividend / remainder width
  localparam int unsigned Q_W   = 17;   // quotient bits, one per divider cell

  localparam logic [7:0] CODE_UNKNOWN = 8'd255;
  localparam logic [7:0] CODE_BELOW   = 8'd253;
  localparam logic [7:0] CODE_ABOVE   = 8'd254;
  localparam logic [7:0] CODE_EMPTY   = 8'd0;
  localparam logic [7:0] CODE_DEAD    = 8'd125;
  localparam logic [7:0] IDX_MAX      = 8'd249;

  localparam logic [15:0] GAMMA_ONE = 16'd4096;

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_HIGH  = 2'd1,
    REG_GAMMA = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_LIN   = 2'd1,
    KIND_CURVE = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic [15:0]        gamma;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic             neg;
    logic [7:0]       code;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
  } div_item_t;

endpackage

`default_nettype wire

>>> hdl/hpim_front.sv
// Front stages: range classification, offsets, dead zone and dividend setup.
// Depends on hpim_pkg.
`default_nettype none

module hpim_front import hpim_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample_value,
  input  logic               sample_unknown,
  output logic [DEN_W-1:0]   den,
  output div_item_t          out_item,
  output logic               out_valid,
  input  logic               out_ready
);

  logic signed [XW-1:0] x, lo, hi;
  logic signed [33:0]   r;
  logic signed [34:0]   t;
  logic [XW-1:0]        at_c, d_c;
  kind_t                kind_c;
  logic [7:0]           code_c;

  // stage 1 registers
  logic         v1;
  kind_t        kind1;
  logic [7:0]   code1;
  logic         neg1;
  logic [XW-1:0] at1, d1;

  logic ld1, ld2;
  logic [39:0]  dz_prod;
  logic [40:0]  lin_num;
  div_item_t    item_c;

  assign x  = {sample_value[31], sample_value};
  assign lo = {cfg.low[31], cfg.low};
  assign hi = {cfg.high[31], cfg.high};
  assign r  = {hi[32], hi} - {lo[32], lo};
  assign t  = {x[32], x, 1'b0} - {{2{lo[32]}}, lo} - {{2{hi[32]}}, hi};
  assign den = r[DEN_W-1:0];

  always_comb begin
    logic [34:0] abs_t;
    abs_t = t[34] ? (35'd0 - t) : t;
    at_c  = abs_t[XW-1:0];
  end

  always_comb begin
    logic [XW-1:0] diff;
    diff = x - lo;
    d_c  = diff;
  end

  always_comb begin
    kind_c = KIND_CODE;
    code_c = CODE_EMPTY;
    if (sample_unknown) begin
      code_c = CODE_UNKNOWN;
    end else if (x < lo) begin
      code_c = CODE_BELOW;
    end else if (x > hi) begin
      code_c = CODE_ABOVE;
    end else if (hi <= lo) begin
      code_c = CODE_EMPTY;
    end else if (cfg.gamma == GAMMA_ONE) begin
      kind_c = KIND_LIN;
    end else begin
      kind_c = KIND_CURVE;
    end
  end

  assign ld2      = !out_valid || out_ready;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= in_valid;
    end
    if (ld1) begin
      kind1 <= kind_c;
      code1 <= code_c;
      neg1  <= t[34];
      at1   <= at_c;
      d1    <= d_c;
    end
  end

  assign dz_prod = 40'(at1) * 40'd125;
  assign lin_num = 41'(d1) * 41'd249;

  always_comb begin
    item_c.kind = kind1;
    item_c.code = code1;
    item_c.neg  = neg1;
    item_c.quo  = '0;
    if (kind1 == KIND_LIN) begin
      item_c.rem = NUM_W'(lin_num);
    end else begin
      item_c.rem = NUM_W'({at1, 16'd0});
    end
    if (kind1 == KIND_CURVE && dz_prod < 40'(r[DEN_W-1:0])) begin
      item_c.kind = KIND_CODE;
      item_c.code = CODE_DEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld2) begin
      out_valid <= v1;
    end
    if (ld2) begin
      out_item <= item_c;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpim_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the request on.
// Depends on hpim_pkg.
`default_nettype none

module hpim_div_cell import hpim_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DEN_W-1:0] den,
  input  div_item_t        in_item,
  input  logic             in_valid,
  output logic             in_ready,
  output div_item_t        out_item,
  output logic             out_valid,
  input  logic             out_ready
);

  logic [NUM_W-1:0] dsh;
  logic             ge;
  div_item_t        nxt;

  assign dsh = NUM_W'(den) << BIT;
  assign ge  = in_item.rem >= dsh;

  always_comb begin
    nxt = in_item;
    if (ge) begin
      nxt.rem = in_item.rem - dsh;
    end
    nxt.quo[BIT] = ge;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_item <= nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpim_back.sv
// Back stages: log2, gamma scaling, exp2 and final index with output register.
// Depends on hpim_pkg.
`default_nettype none

module hpim_back import hpim_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] gamma,
  input  div_item_t   in_item,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  palette_index,
  output logic        out_valid,
  input  logic        out_stall
);

  logic v1, v2, v3, v4, v5;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  kind_t      kind1, kind2, kind3, kind4, kind5;
  logic       neg1, neg2, neg3, neg4, neg5;
  logic [7:0] code1, code2, code3, code4, code5;

  // stage 1: normalize
  logic [4:0]  p_c, p1;
  logic [15:0] f_c, f1;
  logic [32:0] fprod1;
  logic [16:0] m_c;
  kind_t       kind_c;
  logic [7:0]  code_c;

  always_comb begin
    logic [32:0] msh;
    if (in_item.quo == '0) begin
      m_c = 17'd1;
    end else if (in_item.quo > 17'd65536) begin
      m_c = 17'd65536;
    end else begin
      m_c = in_item.quo;
    end
    p_c = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (m_c[i]) begin
        p_c = 5'(i);
      end
    end
    msh = 33'(m_c) << (5'd16 - p_c);
    f_c = msh[15:0];
  end

  always_comb begin
    kind_c = in_item.kind;
    code_c = in_item.code;
    if (in_item.kind == KIND_LIN) begin
      kind_c = KIND_CODE;
      code_c = (in_item.quo > 17'(IDX_MAX)) ? IDX_MAX : in_item.quo[7:0];
    end
  end

  // stage 2: log2 correction
  logic [36:0]        corr_full;
  logic signed [23:0] lg;
  logic [20:0]        negl2;

  assign corr_full = 37'(fprod1) * 37'd11;

  always_comb begin
    logic signed [6:0] pe;
    pe = $signed({2'b00, p1}) - 7'sd16;
    lg = ($signed({{17{pe[6]}}, pe}) <<< 16) + $signed({8'd0, f1})
         + $signed({8'd0, corr_full[36:21]});
  end

  // stage 3: gamma product
  logic [36:0] prod3;

  // stage 4: exp2 split
  logic [37:0] e_sum;
  logic [25:0] e_c;
  logic [26:0] s_sum;
  logic [15:0] g_c, g4;
  logic [10:0] s4;
  logic [32:0] gprod4;

  assign e_sum = 38'(prod3) + 38'd4095;
  assign e_c   = e_sum[37:12];
  assign s_sum = 27'(e_c) + 27'd65535;
  assign g_c   = 16'd0 - e_c[15:0];

  // stage 5: mantissa and shift
  logic [36:0] corr2_full;
  logic [17:0] mant;
  logic [16:0] pw_c, pw5;

  assign corr2_full = 37'(gprod4) * 37'd11;
  assign mant = 18'd65536 + 18'(g4) - 18'(corr2_full[36:21]);

  always_comb begin
    logic [17:0] sh;
    sh = (s4 < 11'd18) ? (mant >> s4[4:0]) : 18'd0;
    pw_c = (sh > 18'd65536) ? 17'd65536 : sh[16:0];
  end

  // stage 6: index
  logic [17:0] base6;
  logic [25:0] num6;
  logic [7:0]  idx6;

  assign base6 = neg5 ? (18'd65536 - 18'(pw5)) : (18'd65536 + 18'(pw5));
  assign num6  = 26'(base6) * 26'd249;
  assign idx6  = (num6[25:17] > 9'(IDX_MAX)) ? IDX_MAX : num6[24:17];

  assign ld6      = !out_valid || !out_stall;
  assign ld5      = !v5 || ld6;
  assign ld4      = !v4 || ld5;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      kind1  <= kind_c;
      code1  <= code_c;
      neg1   <= in_item.neg;
      p1     <= p_c;
      f1     <= f_c;
      fprod1 <= 33'(f_c) * (33'd65536 - 33'(f_c));
    end
    if (ld2) begin
      kind2 <= kind1;
      code2 <= code1;
      neg2  <= neg1;
      negl2 <= lg[23] ? 21'(-lg) : 21'd0;
    end
    if (ld3) begin
      kind3 <= kind2;
      code3 <= code2;
      neg3  <= neg2;
      prod3 <= 37'(negl2) * 37'(gamma);
    end
    if (ld4) begin
      kind4  <= kind3;
      code4  <= code3;
      neg4   <= neg3;
      s4     <= s_sum[26:16];
      g4     <= g_c;
      gprod4 <= 33'(g_c) * (33'd65536 - 33'(g_c));
    end
    if (ld5) begin
      kind5 <= kind4;
      code5 <= code4;
      neg5  <= neg4;
      pw5   <= pw_c;
    end
    if (ld6) begin
      palette_index <= (kind5 == KIND_CODE) ? code5 : idx6;
    end
  end

endmodule

`default_nettype wire

>>> hdl/heat_palette_index_mapper_core.sv
// Top level of the heat palette index mapper: config registers, front, divider chain, back.
// Depends on hpim_pkg, hpim_front, hpim_div_cell, hpim_back and the macros header.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  input    | in_valid / in_stall      | sample_value, sample_unknown
//  output   | out_valid / out_stall    | palette_index
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; stages: 2 front, 17 divider cells, 6 back.
// Each divider cell resolves one quotient bit of the 17-bit normalized magnitude.
// Synchronous reset clears all stage valids and loads the register defaults.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
`default_nettype none
`include "heat_palette_index_mapper_core_macros.svh"

module heat_palette_index_mapper_core import hpim_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_value,
  input  logic               sample_unknown,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         palette_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t             cfg;
  logic             front_ready;
  logic [DEN_W-1:0] den;
  div_item_t        item [Q_W+1];
  logic             vld  [Q_W+1];
  logic             rdy  [Q_W+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low   <= 32'sd0;
      cfg.high  <= 32'sd65536;
      cfg.gamma <= GAMMA_ONE;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW:   cfg.low   <= cfg_data;
        REG_HIGH:  cfg.high  <= cfg_data;
        REG_GAMMA: cfg.gamma <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hpim_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (front_ready),
    .sample_value   (sample_value),
    .sample_unknown (sample_unknown),
    .den            (den),
    .out_item       (item[0]),
    .out_valid      (vld[0]),
    .out_ready      (rdy[0])
  );

  assign in_stall = !front_ready;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    hpim_div_cell #(
      .BIT (Q_W - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .den       (den),
      .in_item   (item[j]),
      .in_valid  (vld[j]),
      .in_ready  (rdy[j]),
      .out_item  (item[j+1]),
      .out_valid (vld[j+1]),
      .out_ready (rdy[j+1])
    );
  end

  hpim_back u_back (
    .clk           (clk),
    .rst           (rst),
    .gamma         (cfg.gamma),
    .in_item       (item[Q_W]),
    .in_valid      (vld[Q_W]),
    .in_ready      (rdy[Q_W]),
    .palette_index (palette_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  `HPIM_ASSERT_ALWAYS(a_index_legal, !out_valid || palette_index <= IDX_MAX || palette_index == CODE_BELOW || palette_index == CODE_ABOVE || palette_index == CODE_UNKNOWN, "palette index outside legal codes")
  `HPIM_ASSERT_NEXT(a_reset_empty, rst, !out_valid, "output valid after reset")
  `HPIM_ASSERT_ALWAYS(a_stall_source, !in_stall || (out_valid && out_stall), "input stalled without output backpressure")

endmodule

`default_nettype wire
